// ===== hdl/amfe_pkg.sv =====
// amfe_pkg: shared types, register and command codes, and width helpers
// for the affine match fit error scorer; depends on nothing
package amfe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int SLOT_W        = 3;
  localparam int CMD_W         = 2;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_COEFS     = 6;
  localparam int NUM_ANCHORS   = 2;

  // square root unit: inputs below 2^31, root of a 63-bit sum
  localparam int SQ_IN_W = 31;
  localparam int ROOT_W  = 32;

  // diagonal in Q.8, divider and reduction widths
  localparam int DIAG_IN_W = 26;
  localparam int DIAG_W    = 25;
  localparam int DIV_SH    = 8;
  localparam int DIV_W     = DIAG_W + DIV_SH;
  localparam int TERM_W    = 36;
  localparam int PROD_W    = 68;
  localparam int QUO_W     = 60;

  localparam int FE_W = 31;
  localparam logic [FE_W-1:0] ERR_MAX = {FE_W{1'b1}};

  localparam logic [CFG_W-1:0] FIT_THR_RST  = 16'd1024;
  localparam logic [CFG_W-1:0] DIST_FAC_RST = 16'd0;
  localparam logic [CFG_W-1:0] IMG_W_RST    = 16'd1;
  localparam logic [CFG_W-1:0] IMG_H_RST    = 16'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCORE       = 2'd0,
    CMD_LOAD_COEF   = 2'd1,
    CMD_LOAD_ANCHOR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_THRESHOLD   = 2'd0,
    REG_DISTANCE_FACTOR = 2'd1,
    REG_IMAGE_WIDTH     = 2'd2,
    REG_IMAGE_HEIGHT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic signed [COORD_W-1:0] coefficient;
  } in_word_t;

  typedef struct packed {
    logic [FE_W-1:0] fit_error;
    logic            is_inlier;
  } out_word_t;

  // largest pre-shift needed to bring a w-bit magnitude below 2^31
  function automatic int norm_kmax(input int w);
    return (w > SQ_IN_W) ? (w - SQ_IN_W) : 0;
  endfunction

  // number of pre-shift stages
  function automatic int norm_j(input int w);
    return $clog2(norm_kmax(w) + 1);
  endfunction

  function automatic int norm_ow(input int w);
    return ROOT_W + norm_kmax(w);
  endfunction

  // magnitude, pre-shift, square, sum, root digits, final shift
  function automatic int norm_lat(input int w);
    return norm_j(w) + ROOT_W + 4;
  endfunction

endpackage

// ===== hdl/amfe_norm.sv =====
// amfe_norm: pipelined euclidean norm floor(sqrt(dx^2 + dy^2)) with range pre-shift
// one root bit per stage; depends on amfe_pkg
module amfe_norm #(
  parameter int W = 32
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [W-1:0]                  dx,
  input  logic signed [W-1:0]                  dy,
  output logic [amfe_pkg::norm_ow(W)-1:0]      root
);

  localparam int J   = amfe_pkg::norm_j(W);
  localparam int KW  = (J > 0) ? J : 1;
  localparam int MXW = (W > amfe_pkg::SQ_IN_W) ? W : amfe_pkg::SQ_IN_W;
  localparam int RW  = amfe_pkg::ROOT_W;
  localparam int SW  = amfe_pkg::SQ_IN_W;
  localparam int OW  = amfe_pkg::norm_ow(W);

  logic [W-1:0]      ax, ay;
  logic [MXW-1:0]    mx_r [0:J];
  logic [MXW-1:0]    my_r [0:J];
  logic [KW-1:0]     k_r  [0:J];
  logic [2*SW-1:0]   sqx_r, sqy_r;
  logic [KW-1:0]     ks_r;
  logic [2*RW-1:0]   sv_r    [0:RW];
  logic [RW:0]       srem_r  [0:RW];
  logic [RW-1:0]     sroot_r [0:RW];
  logic [KW-1:0]     sk_r    [0:RW];
  logic [OW-1:0]     root_r;

  assign ax = dx[W-1] ? W'(-dx) : W'(dx);
  assign ay = dy[W-1] ? W'(-dy) : W'(dy);

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r[0] <= MXW'(ax);
      my_r[0] <= MXW'(ay);
      k_r[0]  <= '0;
    end
  end

  // binary pre-shift, largest step first
  for (genvar s = 0; s < J; s++) begin : g_shift
    localparam int SH = 1 << (J - 1 - s);
    logic big;
    assign big = ((mx_r[s] | my_r[s]) >> (SW - 1 + SH)) != '0;
    always_ff @(posedge clk) begin
      if (en) begin
        mx_r[s+1] <= big ? (mx_r[s] >> SH) : mx_r[s];
        my_r[s+1] <= big ? (my_r[s] >> SH) : my_r[s];
        k_r[s+1]  <= big ? (k_r[s] | KW'(SH)) : k_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r      <= mx_r[J][SW-1:0] * mx_r[J][SW-1:0];
      sqy_r      <= my_r[J][SW-1:0] * my_r[J][SW-1:0];
      ks_r       <= k_r[J];
      sv_r[0]    <= (2*RW)'(sqx_r) + (2*RW)'(sqy_r);
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sk_r[0]    <= ks_r;
    end
  end

  // restoring square root, two radicand bits per stage
  for (genvar i = 1; i <= RW; i++) begin : g_root
    logic [RW+2:0] t, trial, d;
    logic          ge;
    assign t     = {srem_r[i-1], sv_r[i-1][2*RW-1 -: 2]};
    assign trial = (RW+3)'({sroot_r[i-1], 2'b01});
    assign ge    = t >= trial;
    assign d     = t - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[i]  <= ge ? d[RW:0] : t[RW:0];
        sroot_r[i] <= {sroot_r[i-1][RW-2:0], ge};
        sv_r[i]    <= sv_r[i-1] << 2;
        sk_r[i]    <= sk_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= OW'(sroot_r[RW]) << sk_r[RW];
    end
  end

  assign root = root_r;

endmodule

// ===== hdl/affine_match_fit_error_top.sv =====
// affine_match_fit_error_top: scores matches against a loaded affine model
// throughput: one word per cycle while the skid stage is empty; the depth comes from the 32-stage root units
//   and the 60-stage restoring divider for the relaxation term
// reset: registers to their defaults, coefficients and anchors to zero, pipe empty;
//   the free-running diagonal root settles again after a config write or reset
module affine_match_fit_error_top #(
  parameter int FRAC_BITS = amfe_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  amfe_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output amfe_pkg::out_word_t              out_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [amfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [amfe_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CW     = amfe_pkg::COORD_W;
  localparam int PW     = 2*CW - FRAC_BITS;        // floored product
  localparam int EW     = PW + 2;                  // mapped coordinate
  localparam int DW     = EW + 1;                  // residual vector
  localparam int AW     = CW + 1;                  // anchor differences
  localparam int NW     = amfe_pkg::norm_ow(DW);
  localparam int NL     = amfe_pkg::norm_lat(DW);
  localparam int QW     = amfe_pkg::QUO_W;
  localparam int MW     = amfe_pkg::DIV_W;
  localparam int TW     = amfe_pkg::TERM_W;
  localparam int TSW    = NW + 2;
  localparam int ERW    = QW + 1;
  localparam int LAT    = NL + QW + 8;
  localparam int THR_SH = FRAC_BITS - 8;
  localparam int CFW    = amfe_pkg::CFG_W;

  // ---------------- configuration registers ----------------
  logic [CFW-1:0]   fit_thr_r, dist_fac_r, img_w_r, img_h_r;
  logic [2*CFW-1:0] num_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_thr_r  <= amfe_pkg::FIT_THR_RST;
      dist_fac_r <= amfe_pkg::DIST_FAC_RST;
      img_w_r    <= amfe_pkg::IMG_W_RST;
      img_h_r    <= amfe_pkg::IMG_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        amfe_pkg::REG_FIT_THRESHOLD:   fit_thr_r  <= cfg_data;
        amfe_pkg::REG_DISTANCE_FACTOR: dist_fac_r <= cfg_data;
        amfe_pkg::REG_IMAGE_WIDTH:     img_w_r    <= cfg_data;
        amfe_pkg::REG_IMAGE_HEIGHT:    img_h_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight of the relaxation, follows config every cycle
  always_ff @(posedge clk) begin
    num_r <= dist_fac_r * fit_thr_r;
  end

  // diagonal in Q.8: root of (256w)^2 + (256h)^2, free running on config
  logic signed [amfe_pkg::DIAG_IN_W-1:0]      dg_x, dg_y;
  logic [amfe_pkg::norm_ow(amfe_pkg::DIAG_IN_W)-1:0] diag_root;
  logic [MW-1:0]                              dvsr;
  logic                                       diag_zero;

  assign dg_x = {2'b00, img_w_r, 8'h00};
  assign dg_y = {2'b00, img_h_r, 8'h00};

  amfe_norm #(.W(amfe_pkg::DIAG_IN_W)) u_diag (
    .clk  (clk),
    .en   (1'b1),
    .dx   (dg_x),
    .dy   (dg_y),
    .root (diag_root)
  );

  assign dvsr      = {diag_root[amfe_pkg::DIAG_W-1:0], {amfe_pkg::DIV_SH{1'b0}}};
  assign diag_zero = diag_root == '0;

  // ---------------- handshake and pipeline enable ----------------
  // the whole pipe moves together; it holds only when the skid stage is full,
  // so one more word still enters while a finished result waits at the output
  logic en, accept, is_score;
  logic skid_vld_r, skid_vld_nxt, out_vld_r, out_vld_nxt;
  amfe_pkg::out_word_t skid_word_r, skid_word_nxt, out_word_r, out_word_nxt, tail_w;
  logic vld_r [0:LAT-1];

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign is_score = in_word.command == amfe_pkg::CMD_SCORE;

  // ---------------- model state ----------------
  logic signed [CW-1:0] coef_r   [0:amfe_pkg::NUM_COEFS-1];
  logic signed [CW-1:0] anchor_r [0:2*amfe_pkg::NUM_ANCHORS-1];

  // loads take effect after the edge, so a score word accepted at the same
  // edge or earlier still sees the old model through its stage-one capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < amfe_pkg::NUM_COEFS; i++) coef_r[i] <= '0;
      for (int i = 0; i < 2*amfe_pkg::NUM_ANCHORS; i++) anchor_r[i] <= '0;
    end else if (accept) begin
      if (in_word.command == amfe_pkg::CMD_LOAD_COEF) begin
        for (int i = 0; i < amfe_pkg::NUM_COEFS; i++) begin
          if (in_word.slot == amfe_pkg::SLOT_W'(i)) coef_r[i] <= in_word.coefficient;
        end
      end
      if (in_word.command == amfe_pkg::CMD_LOAD_ANCHOR) begin
        for (int i = 0; i < amfe_pkg::NUM_ANCHORS; i++) begin
          if (in_word.slot == amfe_pkg::SLOT_W'(i)) begin
            anchor_r[2*i]   <= in_word.right_x;
            anchor_r[2*i+1] <= in_word.right_y;
          end
        end
      end
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= accept && is_score;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // ---------------- stage 1: products and anchor differences ----------------
  logic signed [CW-1:0]   rx, ry, lx, ly;
  logic signed [2*CW-1:0] p_nxt [0:3];
  logic signed [AW-1:0]   ad_nxt [0:5];
  logic signed [2*CW-1:0] p_r [0:3];
  logic signed [CW-1:0]   c2_r, c5_r, lx1_r, ly1_r;
  logic signed [AW-1:0]   ad1_r [0:5];

  assign rx = in_word.right_x;
  assign ry = in_word.right_y;
  assign lx = in_word.left_x;
  assign ly = in_word.left_y;

  always_comb begin
    p_nxt[0]  = coef_r[0] * rx;
    p_nxt[1]  = coef_r[1] * ry;
    p_nxt[2]  = coef_r[3] * rx;
    p_nxt[3]  = coef_r[4] * ry;
    ad_nxt[0] = AW'(rx) - AW'(anchor_r[0]);
    ad_nxt[1] = AW'(ry) - AW'(anchor_r[1]);
    ad_nxt[2] = AW'(rx) - AW'(anchor_r[2]);
    ad_nxt[3] = AW'(ry) - AW'(anchor_r[3]);
    ad_nxt[4] = AW'(anchor_r[0]) - AW'(anchor_r[2]);
    ad_nxt[5] = AW'(anchor_r[1]) - AW'(anchor_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) p_r[i] <= p_nxt[i];
      for (int i = 0; i < 6; i++) ad1_r[i] <= ad_nxt[i];
      c2_r  <= coef_r[2];
      c5_r  <= coef_r[5];
      lx1_r <= lx;
      ly1_r <= ly;
    end
  end

  // ---------------- stage 2: floored products summed ----------------
  logic signed [EW-1:0] ex_r, ey_r;
  logic signed [CW-1:0] lx2_r, ly2_r;
  logic signed [AW-1:0] ad2_r [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r  <= EW'($signed(p_r[0][2*CW-1:FRAC_BITS])) +
               EW'($signed(p_r[1][2*CW-1:FRAC_BITS])) + EW'(c2_r);
      ey_r  <= EW'($signed(p_r[2][2*CW-1:FRAC_BITS])) +
               EW'($signed(p_r[3][2*CW-1:FRAC_BITS])) + EW'(c5_r);
      lx2_r <= lx1_r;
      ly2_r <= ly1_r;
      for (int i = 0; i < 6; i++) ad2_r[i] <= ad1_r[i];
    end
  end

  // ---------------- stage 3: residual vector ----------------
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [DW-1:0] ad3_r [0:5];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'(lx2_r) - DW'(ex_r);
      dy_r <= DW'(ly2_r) - DW'(ey_r);
      for (int i = 0; i < 6; i++) ad3_r[i] <= DW'(ad2_r[i]);
    end
  end

  // ---------------- norms: residual and the three triangle sides ----------------
  logic [NW-1:0] n_dist, n_a, n_b, n_ab;

  amfe_norm #(.W(DW)) u_norm_dist (
    .clk (clk), .en (en), .dx (dx_r), .dy (dy_r), .root (n_dist)
  );
  amfe_norm #(.W(DW)) u_norm_a (
    .clk (clk), .en (en), .dx (ad3_r[0]), .dy (ad3_r[1]), .root (n_a)
  );
  amfe_norm #(.W(DW)) u_norm_b (
    .clk (clk), .en (en), .dx (ad3_r[2]), .dy (ad3_r[3]), .root (n_b)
  );
  amfe_norm #(.W(DW)) u_norm_ab (
    .clk (clk), .en (en), .dx (ad3_r[4]), .dy (ad3_r[5]), .root (n_ab)
  );

  // distance rides along the divider in its own delay line
  logic [NW-1:0] dist_r [0:QW+2];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r[0] <= n_dist;
      for (int i = 1; i <= QW + 2; i++) dist_r[i] <= dist_r[i-1];
    end
  end

  // ---------------- triangle term, clamped at zero ----------------
  logic [TSW-1:0] tsum;
  logic [TW-1:0]  term_r;

  assign tsum = TSW'(n_a) + TSW'(n_b) - TSW'(n_ab);

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= tsum[TSW-1] ? '0 : tsum[TW-1:0];
    end
  end

  // ---------------- weight times term, split into two partial products ----------------
  logic [2*CW-1:0] plo_r;
  logic [TW-1:0]   phi_r;
  logic [amfe_pkg::PROD_W-1:0] nsum;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= num_r * term_r[CW-1:0];
      phi_r <= num_r * term_r[TW-1:CW];
    end
  end

  assign nsum = amfe_pkg::PROD_W'(plo_r) + (amfe_pkg::PROD_W'(phi_r) << CW);

  // ---------------- restoring divider, one quotient bit per stage ----------------
  // the top dividend bits sit below the divisor, so the quotient fits QW bits
  logic [MW-1:0] dv_rem_r [0:QW];
  logic [QW-1:0] dv_n_r   [0:QW];
  logic [QW-1:0] dv_q_r   [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= MW'(nsum[amfe_pkg::PROD_W-1:QW]);
      dv_n_r[0]   <= nsum[QW-1:0];
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_div
    logic [MW:0] t, d;
    logic        ge;
    assign t  = {dv_rem_r[s-1], dv_n_r[s-1][QW-1]};
    assign ge = t >= (MW+1)'(dvsr);
    assign d  = t - (MW+1)'(dvsr);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[s] <= ge ? d[MW-1:0] : t[MW-1:0];
        dv_n_r[s]   <= dv_n_r[s-1] << 1;
        dv_q_r[s]   <= {dv_q_r[s-1][QW-2:0], ge};
      end
    end
  end

  // ---------------- error, clamp, saturation and threshold ----------------
  logic [QW-1:0]  red;
  logic [ERW-1:0] ediff;
  logic [QW-1:0]  err_r;
  logic [QW-1:0]  thr_q;
  logic [amfe_pkg::FE_W-1:0] fe_r;
  logic           inl_r;

  // zero diagonal means no relaxation
  assign red   = diag_zero ? '0 : dv_q_r[QW];
  assign ediff = ERW'(dist_r[QW+2]) - ERW'(red);
  assign thr_q = QW'(fit_thr_r) << THR_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      err_r <= ediff[ERW-1] ? '0 : ediff[QW-1:0];
      fe_r  <= (err_r > QW'(amfe_pkg::ERR_MAX)) ? amfe_pkg::ERR_MAX
                                                : err_r[amfe_pkg::FE_W-1:0];
      inl_r <= err_r <= thr_q;
    end
  end

  // ---------------- output register with skid stage ----------------
  always_comb begin
    tail_w.fit_error = fe_r;
    tail_w.is_inlier = inl_r;
  end

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_word_nxt  = out_word_r;
    skid_vld_nxt  = skid_vld_r;
    skid_word_nxt = skid_word_r;
    if (skid_vld_r) begin
      // pipe frozen; drain the skid word once the output is taken
      if (!out_stall) begin
        out_word_nxt = skid_word_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (!out_vld_r || !out_stall) begin
      out_vld_nxt  = vld_r[LAT-1];
      out_word_nxt = tail_w;
    end else if (vld_r[LAT-1]) begin
      // output held: park the word leaving the pipe
      skid_vld_nxt  = 1'b1;
      skid_word_nxt = tail_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

// ===== dv/tb_affine_match_fit_error_top.sv =====
// tb_affine_match_fit_error_top: self-checking bench for the affine match fit error scorer
// depends on amfe_pkg and affine_match_fit_error_top; predicts each score word and
// compares it with the block output under random sender idling and receiver stalls
module tb_affine_match_fit_error_top;

  localparam int FRAC = 16;
  localparam logic [amfe_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  // block latency plus margin, used for the drain and before register writes
  localparam int DRAIN_CYCLES = 130;
  // diagonal root settling after a register write
  localparam int SETTLE_CYCLES = 40;
  localparam logic [63:0] RED_CAP = 64'h3FFF_FFFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  amfe_pkg::in_word_t in_word;
  logic out_valid;
  logic out_stall;
  amfe_pkg::out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [amfe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [amfe_pkg::CFG_W-1:0] cfg_data;

  // scorer model state
  logic [15:0] thr_m, dfac_m, wid_m, hgt_m;
  longint coef_m [amfe_pkg::NUM_COEFS];
  longint anchor_m [4];

  amfe_pkg::out_word_t score_q [$];
  int errors;
  int idle_pct;
  int stall_pct;

  affine_match_fit_error_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #600000;
    $display("Verification failed");
    $finish;
  end

  // bitwise integer square root, floor
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // euclidean length with pre-shift of wide magnitudes
  function automatic longint dist2d(input longint dx, input longint dy);
    logic [63:0] ux, uy;
    int k;
    ux = (dx < 0) ? 64'(-dx) : 64'(dx);
    uy = (dy < 0) ? 64'(-dy) : 64'(dy);
    k = 0;
    while ((ux | uy) >= 64'h8000_0000) begin
      ux = ux >> 1;
      uy = uy >> 1;
      k++;
    end
    return longint'(isqrt(ux * ux + uy * uy) << k);
  endfunction

  // expected score word for one match, from the model state
  function automatic amfe_pkg::out_word_t predict_score(input amfe_pkg::in_word_t w);
    longint rx, ry, ex, ey, res_len, term, err;
    logic [63:0] num, diag8, red, wv, hv;
    logic [127:0] quo;
    amfe_pkg::out_word_t o;
    rx = longint'(w.right_x);
    ry = longint'(w.right_y);
    ex = ((coef_m[0] * rx) >>> FRAC) + ((coef_m[1] * ry) >>> FRAC) + coef_m[2];
    ey = ((coef_m[3] * rx) >>> FRAC) + ((coef_m[4] * ry) >>> FRAC) + coef_m[5];
    res_len = dist2d(longint'(w.left_x) - ex, longint'(w.left_y) - ey);
    term = dist2d(rx - anchor_m[0], ry - anchor_m[1]) + dist2d(rx - anchor_m[2], ry - anchor_m[3])
         - dist2d(anchor_m[0] - anchor_m[2], anchor_m[1] - anchor_m[3]);
    if (term < 0) term = 0;
    num = 64'(dfac_m) * 64'(thr_m);
    wv = 64'(wid_m);
    hv = 64'(hgt_m);
    diag8 = isqrt((wv * wv + hv * hv) << 16);
    red = 0;
    if (num != 0 && diag8 != 0 && term != 0) begin
      quo = (128'(num) * 128'(term)) / 128'(diag8 << 8);
      red = (quo > 128'(RED_CAP)) ? RED_CAP : quo[63:0];
    end
    err = res_len - longint'(red);
    if (err < 0) err = 0;
    o.fit_error = (err > longint'(amfe_pkg::ERR_MAX)) ? amfe_pkg::ERR_MAX
                                                     : err[amfe_pkg::FE_W-1:0];
    o.is_inlier = (64'(err) <= (64'(thr_m) << (FRAC - 8)));
    return o;
  endfunction

  // apply one accepted word to the model
  task automatic model_word(input amfe_pkg::in_word_t w);
    case (w.command)
      amfe_pkg::CMD_LOAD_COEF: begin
        if (w.slot < amfe_pkg::NUM_COEFS) coef_m[w.slot] = longint'(w.coefficient);
      end
      amfe_pkg::CMD_LOAD_ANCHOR: begin
        if (w.slot < amfe_pkg::NUM_ANCHORS) begin
          anchor_m[2 * w.slot] = longint'(w.right_x);
          anchor_m[2 * w.slot + 1] = longint'(w.right_y);
        end
      end
      amfe_pkg::CMD_SCORE: score_q.push_back(predict_score(w));
      default: ;
    endcase
  endtask

  // present one word, honoring the sender idle rate, until accepted
  task automatic send_word(input amfe_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_word(w);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for the pipe to empty; loads give no word so allow the full latency too
  task automatic wait_idle();
    wait (score_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(input amfe_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      amfe_pkg::REG_FIT_THRESHOLD: thr_m = val;
      amfe_pkg::REG_DISTANCE_FACTOR: dfac_m = val;
      amfe_pkg::REG_IMAGE_WIDTH: wid_m = val;
      default: hgt_m = val;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] dfac,
                          input logic [15:0] wd, input logic [15:0] ht);
    stop_sending();
    wait_idle();
    write_reg(amfe_pkg::REG_FIT_THRESHOLD, thr);
    write_reg(amfe_pkg::REG_DISTANCE_FACTOR, dfac);
    write_reg(amfe_pkg::REG_IMAGE_WIDTH, wd);
    write_reg(amfe_pkg::REG_IMAGE_HEIGHT, ht);
    cfg_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic amfe_pkg::in_word_t mk_word(input logic [amfe_pkg::CMD_W-1:0] cmd,
                                                 input logic [2:0] slot,
                                                 input logic [31:0] lx, input logic [31:0] ly,
                                                 input logic [31:0] rx, input logic [31:0] ry,
                                                 input logic [31:0] cf);
    amfe_pkg::in_word_t w;
    w.command = cmd;
    w.slot = slot;
    w.left_x = lx;
    w.left_y = ly;
    w.right_x = rx;
    w.right_y = ry;
    w.coefficient = cf;
    return w;
  endfunction

  // coordinate: mostly image-sized pixel positions, sometimes any 32-bit value
  function automatic logic [31:0] rnd_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(32'h0800_0000)) - 32'h0200_0000;
  endfunction

  // coefficient: near-identity mostly, sometimes anything
  function automatic logic [31:0] rnd_coef(input int slot);
    if ($urandom_range(4) == 0) return $urandom;
    if (slot == 2 || slot == 5) return 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
    return ((slot == 0 || slot == 4) ? 32'h0001_0000 : 32'h0)
           + 32'($urandom_range(32'h4000)) - 32'h2000;
  endfunction

  function automatic amfe_pkg::in_word_t rnd_score();
    return mk_word(amfe_pkg::CMD_SCORE, 3'($urandom), rnd_coord(), rnd_coord(),
                   rnd_coord(), rnd_coord(), $urandom);
  endfunction

  // checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (score_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual err=%h inl=%b",
                 $time, out_word.fit_error, out_word.is_inlier);
        errors++;
      end else begin
        if (out_word.fit_error !== score_q[0].fit_error) begin
          $display("%0t: fit_error mismatch, expected %h, actual %h",
                   $time, score_q[0].fit_error, out_word.fit_error);
          errors++;
        end
        if (out_word.is_inlier !== score_q[0].is_inlier) begin
          $display("%0t: is_inlier mismatch, expected %b, actual %b",
                   $time, score_q[0].is_inlier, out_word.is_inlier);
          errors++;
        end
        void'(score_q.pop_front());
      end
    end
  end

  // receiver stall at the phase rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // reset defaults, zero model: error is the distance to the left point
  task automatic test_reset_defaults();
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0003_0000, 32'h0004_0000,
                      32'h0, 32'h0, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0004_0000, 32'h0, 32'h0, 32'h0, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0004_0001, 32'h0, 32'h0, 32'h0, 32'h0));
  endtask

  // loads, out of range slots and the unused command
  task automatic test_loads();
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h0001_0000));
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h0001_0000));
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd2, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'hFFFE_8000));
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd6, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h7FFF_FFFF));
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd7, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h8000_0000));
    send_word(mk_word(CMD_UNUSED, 3'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0010_0000, 32'h0020_0000,
                      32'h0011_0000, 32'h0020_0000, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'd0, 32'h0, 32'h0, 32'h0010_0000,
                      32'h0010_0000, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'd1, 32'h0, 32'h0, 32'h0050_0000,
                      32'h0010_0000, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'd2, 32'h0, 32'h0, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'd5, 32'h0, 32'h0, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h0));
  endtask

  // relaxation on, then zero image size, then the largest threshold and distance factor
  task automatic test_relaxation();
    set_regs(16'h0200, 16'h0100, 16'd640, 16'd480);
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0030_0000, 32'h0010_0000,
                      32'h0030_0000, 32'h0030_0000, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0, 32'h0, 32'h0300_0000,
                      32'hFD00_0000, 32'h0));
    set_regs(16'h0200, 16'h0100, 16'd0, 16'd0);
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0, 32'h0, 32'h0300_0000,
                      32'hFD00_0000, 32'h0));
    set_regs(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0, 32'h0, 32'h0100_0000, 32'h0, 32'h0));
  endtask

  // extreme coefficients and points: wide distances and saturation
  task automatic test_saturation();
    set_regs(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h7FFF_FFFF));
    send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h8000_0000));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    send_word(mk_word(amfe_pkg::CMD_SCORE, 3'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
  endtask

  // random phases, each with its own register setting and idling mix
  task automatic test_random_phases();
    int ip [4] = '{0, 75, 0, 35};
    int sp [4] = '{0, 0, 75, 35};
    int n;
    int r;
    int s;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = 0;
      stall_pct = 0;
      if (ph == 3) set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else set_regs(16'($urandom_range(16'h1000)), 16'($urandom),
                    16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
      idle_pct = ip[ph];
      stall_pct = sp[ph];
      // fresh model: all six coefficients and both anchors
      for (int i = 0; i < amfe_pkg::NUM_COEFS; i++)
        send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'(i), $urandom, $urandom, $urandom,
                          $urandom, rnd_coef(i)));
      for (int i = 0; i < amfe_pkg::NUM_ANCHORS; i++)
        send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'(i), $urandom, $urandom, rnd_coord(),
                          rnd_coord(), $urandom));
      n = 0;
      while (n < 100) begin
        r = $urandom_range(99);
        s = $urandom_range(7);
        if (r < 80) begin
          send_word(rnd_score());
        end else if (r < 90) begin
          send_word(mk_word(amfe_pkg::CMD_LOAD_COEF, 3'(s), $urandom, $urandom, $urandom,
                            $urandom, rnd_coef(s)));
        end else if (r < 97) begin
          send_word(mk_word(amfe_pkg::CMD_LOAD_ANCHOR, 3'(s), $urandom, $urandom,
                            rnd_coord(), rnd_coord(), $urandom));
        end else begin
          send_word(mk_word(CMD_UNUSED, 3'(s), $urandom, $urandom, $urandom, $urandom,
                            $urandom));
          n--;
        end
        n++;
      end
    end
    stop_sending();
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = amfe_pkg::REG_FIT_THRESHOLD;
    cfg_data = '0;
    thr_m = amfe_pkg::FIT_THR_RST;
    dfac_m = amfe_pkg::DIST_FAC_RST;
    wid_m = amfe_pkg::IMG_W_RST;
    hgt_m = amfe_pkg::IMG_H_RST;
    for (int i = 0; i < amfe_pkg::NUM_COEFS; i++) coef_m[i] = 0;
    for (int i = 0; i < 4; i++) anchor_m[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // let the diagonal root settle after reset
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_reset_defaults();
    test_loads();
    test_relaxation();
    test_saturation();
    test_random_phases();

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
